/* hw/rtl/zctd_pkg.sv */
// ----------------------------------------------------------------------------
// zctd_pkg - shared types and constants of the z-character text decoder
// Result and lane record types, alphabet and construct codes, the A2 table.
// ----------------------------------------------------------------------------
package zctd_pkg;

	// result kinds
	typedef enum logic [1:0] {
		KindChar   = 2'd0,
		KindAbbrev = 2'd1,
		KindEnd    = 2'd2
	} kind_t;

	// alphabets
	localparam logic [1:0] AlphaLower = 2'd0;
	localparam logic [1:0] AlphaUpper = 2'd1;
	localparam logic [1:0] AlphaPunct = 2'd2;

	// multi-z-char construct stages
	localparam logic [1:0] MsIdle   = 2'd0;
	localparam logic [1:0] MsAbbrev = 2'd1;
	localparam logic [1:0] MsEscHi  = 2'd2;
	localparam logic [1:0] MsEscLo  = 2'd3;

	// register index codes (byte address bit 2)
	localparam logic RegVersion = 1'b0;
	localparam logic RegBase    = 1'b1;

	// special z-chars and codes
	localparam logic [4:0] ZSpace     = 5'd0;
	localparam logic [4:0] ZEscape    = 5'd6;
	localparam logic [4:0] ZFirstChar = 5'd6;
	localparam logic [4:0] ZLastAbbr  = 5'd3;
	localparam logic [9:0] CodeSpace  = 10'd32;
	localparam logic [3:0] ModernVer  = 4'd3;

	localparam int MaxRes   = 4;
	localparam int NumLanes = 3;

	// one z-char pre-decoded against all three alphabets
	typedef struct packed {
		logic [4:0] zc;
		logic [6:0] a0;
		logic [6:0] a1;
		logic [6:0] a2;
	} lane_t;

	typedef struct packed {
		kind_t       kind;
		logic [9:0]  code;
		logic [15:0] addr;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [1:0] salph;
		logic       pend;
		logic [1:0] lock;
		logic [1:0] mstage;
		logic [4:0] held;
	} dec_state_t;

	// results of one word handed from the merge stage to the output queue
	typedef struct packed {
		result_t [MaxRes-1:0] res;
		logic [2:0]           cnt;
	} merge_out_t;

	// step an alphabet one or two places on, modulo three
	function automatic logic [1:0] rot3(input logic [1:0] a, input logic two);
		logic [2:0] s;
		s = {1'b0, a} + (two ? 3'd2 : 3'd1);
		if (s >= 3'd3) begin
			s = s - 3'd3;
		end
		return s[1:0];
	endfunction

	// punctuation and digit alphabet
	function automatic logic [6:0] a2_char(input logic [4:0] z);
		logic [6:0] c;
		case (z) inside
			5'd7:        c = 7'd10;
			[5'd8:5'd17]: c = 7'(z) + 7'd40;
			5'd18:       c = 7'd46;
			5'd19:       c = 7'd44;
			5'd20:       c = 7'd33;
			5'd21:       c = 7'd63;
			5'd22:       c = 7'd95;
			5'd23:       c = 7'd35;
			5'd24:       c = 7'd39;
			5'd25:       c = 7'd34;
			5'd26:       c = 7'd47;
			5'd27:       c = 7'd92;
			5'd28:       c = 7'd45;
			5'd29:       c = 7'd58;
			5'd30:       c = 7'd40;
			5'd31:       c = 7'd41;
			default:     c = 7'd32;
		endcase
		return c;
	endfunction

endpackage

/* hw/rtl/zchar_text_decoder_core.sv */
// ----------------------------------------------------------------------------
// zchar_text_decoder_core - packed text word to character stream decoder
// Splits each 16-bit text word into three z-chars and decodes them.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall with code_word; a beat is taken when
//   in_valid is high and in_stall low. Output channel: out_valid / out_stall
//   with kind, char_code, abbrev_entry_address and last; last flags the
//   final result beat of each word. A word that only shifts or opens a
//   construct gives no beat.
//   Registers over the APB port: 0x0 story_version, 0x4 abbrev_table_base;
//   write them only while the block is idle.
//   A word passes the stage register, is then merged into the result queue,
//   and its results leave through the output register, in that order.
//   Throughput: one word per cycle while words give at most one result and
//   out_stall is low; a word with more results (up to four: three characters
//   and the end marker) holds the next word back on the single result channel.
//   Reset clears decoder state and queue and loads version 3, base 0.
//   While out_stall is high the output beat holds; the queue fills and
//   in_stall rises once the staged word cannot move on.
// ----------------------------------------------------------------------------
module zchar_text_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] code_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [9:0]  char_code,
	output logic [15:0] abbrev_entry_address,
	output logic        last
);

	logic [3:0]                               version_q;
	logic [15:0]                              base_q;
	zctd_pkg::lane_t [zctd_pkg::NumLanes-1:0] lane_d;
	zctd_pkg::lane_t [zctd_pkg::NumLanes-1:0] lanes_s1;
	logic                                     eos_s1;
	logic                                     valid_s1;
	logic                                     in_acc;
	logic                                     take;
	logic                                     free;
	zctd_pkg::merge_out_t                     mo;
	zctd_pkg::result_t                        out_res;

	// register file
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q <= 4'd3;
			base_q    <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				zctd_pkg::RegVersion: version_q <= pwdata[3:0];
				zctd_pkg::RegBase:    base_q    <= pwdata[15:0];
				default:              ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			zctd_pkg::RegVersion: prdata = {28'd0, version_q};
			zctd_pkg::RegBase:    prdata = {16'd0, base_q};
			default:              prdata = '0;
		endcase
	end

	// one lookup lane per z-char, highest z-char first
	for (genvar g = 0; g < zctd_pkg::NumLanes; g++) begin : g_lane
		zctd_lane u_lane (
			.zc   (code_word[14-5*g -: 5]),
			.lane (lane_d[g])
		);
	end

	// lane stage register
	assign take     = valid_s1 && free;
	assign in_stall = valid_s1 && !take;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_acc || (valid_s1 && !take);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			lanes_s1 <= lane_d;
			eos_s1   <= code_word[15];
		end
	end

	// merge the lanes through the shift state
	zctd_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.lanes   (lanes_s1),
		.eos     (eos_s1),
		.version (version_q),
		.base    (base_q),
		.mo      (mo)
	);

	// result queue and output register
	zctd_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.mo        (mo),
		.out_stall (out_stall),
		.free      (free),
		.out_valid (out_valid),
		.out_res   (out_res)
	);

	assign kind                 = out_res.kind;
	assign char_code            = out_res.code;
	assign abbrev_entry_address = out_res.addr;
	assign last                 = out_res.last;

endmodule

/* hw/rtl/zctd_lane.sv */
// ----------------------------------------------------------------------------
// zctd_lane - per z-char alphabet lookup
// Looks one z-char up in the lowercase, uppercase and punctuation alphabets.
// ----------------------------------------------------------------------------
module zctd_lane (
	input  logic [4:0]      zc,
	output zctd_pkg::lane_t lane
);

	// 'a' is z-char 6, 'A' likewise
	always_comb begin
		lane.zc = zc;
		lane.a0 = 7'(zc) + 7'd91;
		lane.a1 = 7'(zc) + 7'd59;
		lane.a2 = zctd_pkg::a2_char(zc);
	end

endmodule

/* hw/rtl/zctd_merge.sv */
// ----------------------------------------------------------------------------
// zctd_merge - shift state chain over the three lanes of one word
// Resolves shifts, locks, abbreviations and escapes in z-char order and
// packs the word's results, with the end marker on a final word, into one record.
// ----------------------------------------------------------------------------
module zctd_merge (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     take,
	input  zctd_pkg::lane_t [zctd_pkg::NumLanes-1:0] lanes,
	input  logic                                     eos,
	input  logic [3:0]                               version,
	input  logic [15:0]                              base,
	output zctd_pkg::merge_out_t                     mo
);

	typedef struct packed {
		zctd_pkg::dec_state_t st;
		logic                 emit;
		zctd_pkg::result_t    res;
	} step_t;

	zctd_pkg::dec_state_t st_q;
	zctd_pkg::dec_state_t st_d;
	logic                 modern;

	assign modern = (version >= zctd_pkg::ModernVer);

	// decode one z-char against the running state
	function automatic step_t zstep(input zctd_pkg::dec_state_t s,
			input zctd_pkg::lane_t l, input logic mdn, input logic [15:0] b);
		step_t      r;
		logic [1:0] a;
		logic [6:0] idx;
		r.st   = s;
		r.emit = 1'b0;
		r.res  = '0;
		a      = s.pend ? s.salph : s.lock;
		idx    = {s.held[1:0] - 2'd1, l.zc};
		case (s.mstage)
			zctd_pkg::MsAbbrev: begin
				r.emit      = 1'b1;
				r.res.kind  = zctd_pkg::KindAbbrev;
				r.res.addr  = b + {8'd0, idx, 1'b0};
				r.st.mstage = zctd_pkg::MsIdle;
				r.st.held   = '0;
			end
			zctd_pkg::MsEscHi: begin
				r.st.held   = l.zc;
				r.st.mstage = zctd_pkg::MsEscLo;
			end
			zctd_pkg::MsEscLo: begin
				r.emit      = 1'b1;
				r.res.kind  = zctd_pkg::KindChar;
				r.res.code  = {s.held, l.zc};
				r.st.mstage = zctd_pkg::MsIdle;
				r.st.held   = '0;
			end
			default: begin
				if (l.zc == zctd_pkg::ZSpace) begin
					r.emit     = 1'b1;
					r.res.code = zctd_pkg::CodeSpace;
					r.st.salph = '0;
					r.st.pend  = 1'b0;
				end else if (l.zc < zctd_pkg::ZFirstChar) begin
					if (mdn) begin
						if (l.zc <= zctd_pkg::ZLastAbbr) begin
							r.st.mstage = zctd_pkg::MsAbbrev;
							r.st.held   = l.zc;
						end else begin
							r.st.salph = zctd_pkg::rot3(a, l.zc == 5'd5);
							r.st.pend  = 1'b1;
						end
					end else if (l.zc inside {5'd2, 5'd3}) begin
						r.st.salph = zctd_pkg::rot3(a, l.zc == 5'd3);
						r.st.pend  = 1'b1;
					end else if (l.zc inside {5'd4, 5'd5}) begin
						r.st.lock = zctd_pkg::rot3(s.lock, l.zc == 5'd5);
					end else begin
						r.st.salph = '0;
						r.st.pend  = 1'b0;
					end
				end else if (a == zctd_pkg::AlphaPunct && l.zc == zctd_pkg::ZEscape) begin
					r.st.mstage = zctd_pkg::MsEscHi;
					r.st.salph  = '0;
					r.st.pend   = 1'b0;
				end else begin
					r.emit = 1'b1;
					case (a)
						zctd_pkg::AlphaLower: r.res.code = {3'd0, l.a0};
						zctd_pkg::AlphaUpper: r.res.code = {3'd0, l.a1};
						default:              r.res.code = {3'd0, l.a2};
					endcase
					r.st.salph = '0;
					r.st.pend  = 1'b0;
				end
			end
		endcase
		return r;
	endfunction

	// chain the lanes in z-char order, then append the end marker on a final word
	always_comb begin
		zctd_pkg::dec_state_t s;
		step_t                r;
		logic [2:0]           n;
		logic [2:0]           nm1;
		s  = st_q;
		n  = '0;
		mo = '0;
		for (int i = 0; i < zctd_pkg::NumLanes; i++) begin
			r = zstep(s, lanes[i], modern, base);
			s = r.st;
			if (r.emit) begin
				mo.res[n[1:0]] = r.res;
				n = n + 3'd1;
			end
		end
		if (eos) begin
			mo.res[n[1:0]].kind = zctd_pkg::KindEnd;
			n = n + 3'd1;
			s = '0;
			s.lock = r.st.lock;
		end
		nm1 = n - 3'd1;
		if (n != 3'd0) begin
			mo.res[nm1[1:0]].last = 1'b1;
		end
		mo.cnt = n;
		st_d   = s;
	end

	// decoder state advances once per merged word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (take) begin
			st_q <= st_d;
		end
	end

endmodule

/* hw/rtl/zctd_outq.sv */
// ----------------------------------------------------------------------------
// zctd_outq - result queue and output register
// Holds the results of one word and hands them out one beat at a time.
// ----------------------------------------------------------------------------
module zctd_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  zctd_pkg::merge_out_t mo,
	input  logic                 out_stall,
	output logic                 free,
	output logic                 out_valid,
	output zctd_pkg::result_t    out_res
);

	zctd_pkg::result_t [zctd_pkg::MaxRes-1:0] res_q;
	logic [2:0]                               rem_q;
	logic [1:0]                               rd_q;
	logic                                     out_valid_q;
	zctd_pkg::result_t                        out_q;
	logic                                     move;

	assign move      = (rem_q != 3'd0) && (!out_valid_q || !out_stall);
	assign free      = (rem_q == 3'd0) || (rem_q == 3'd1 && move);
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	// queue bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			rd_q  <= '0;
		end else if (load) begin
			rem_q <= mo.cnt;
			rd_q  <= '0;
		end else if (move) begin
			rem_q <= rem_q - 3'd1;
			rd_q  <= rd_q + 2'd1;
		end
	end

	// result entries
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= mo.res;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_q <= res_q[rd_q];
		end
	end

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= 3'(zctd_pkg::MaxRes))
		else $error("result queue count beyond capacity");

	a_load_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> rem_q == $past(mo.cnt))
		else $error("queue count does not follow the loaded word");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q != 3'd0 && !move |=> $stable(rem_q) && $stable(rd_q))
		else $error("queue advanced without a beat moving");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.kind != zctd_pkg::KindEnd || out_q.last))
		else $error("end marker not flagged last");

endmodule
